@@ rtl/sv39_page_table_walker_assert.svh @@
// Assertion macros for the Sv39 page-table walker checker.
// No dependencies; included by the checker file.
`ifndef SV39_PAGE_TABLE_WALKER_ASSERT_SVH
`define SV39_PAGE_TABLE_WALKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SV39PTW_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define SV39PTW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ rtl/sv39ptw_pkg.sv @@
// Shared types and constants for the Sv39 page-table walker.
// No dependencies; used by the controller, datapath, top level and checker.
`timescale 1ns / 1ps
`default_nettype none

package sv39ptw_pkg;

  // Default number of local page-table pages
  localparam int TablePagesDef = 8;
  // Entries per table page and index width per level
  localparam int EntriesPerPage = 512;
  localparam int LevelIdxW      = 9;
  localparam int PpnW           = 44;
  localparam int OffsetW        = 12;
  localparam int VaW            = 39;
  localparam int EntryIdxW      = 12;
  localparam int PteW           = 64;
  localparam int RootW          = 3;

  // PTE bit positions
  localparam int PteValidBit = 0;
  localparam int PteUserBit  = 4;
  localparam int PtePpnLsb   = 10;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_LARGE    = 3'd1,
    ST_MID_INVALID  = 3'd2,
    ST_LEAF_INVALID = 3'd3,
    ST_NOT_USER     = 3'd4,
    ST_OUTSIDE      = 3'd5
  } status_e;

  // Input command codes
  typedef enum logic {
    CMD_WRITE     = 1'b0,
    CMD_TRANSLATE = 1'b1
  } command_e;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_L2,
    S_L1,
    S_L0
  } state_e;

  // Read address source for the table store
  typedef enum logic [1:0] {
    SEL_ROOT,
    SEL_MID,
    SEL_LEAF
  } lvl_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     clr_en;
    logic     wr_en;
    logic     rd_en;
    lvl_sel_e rd_sel;
    logic     va_load;
    logic     res_load;
    logic     res_pass_ppn;
    logic     res_zero_off;
    status_e  res_status;
  } wk_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic va_big;
    logic root_out;
    logic pte_valid;
    logic pte_out;
    logic user_fail;
  } wk_sts_t;

endpackage

`default_nettype wire

@@ rtl/sv39ptw_ctrl.sv @@
// Walk controller: clearing pass, command decode and level sequencing.
// Depends on sv39ptw_pkg; drives the datapath through wk_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module sv39ptw_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic                 command_i,
  input  wire sv39ptw_pkg::wk_sts_t sts_i,
  output sv39ptw_pkg::wk_cmd_t      cmd_o,
  output logic                      busy_o
);

  sv39ptw_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sv39ptw_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.rd_sel      = sv39ptw_pkg::SEL_ROOT;
    cmd_o.res_status  = sv39ptw_pkg::ST_OK;
    case (state_q)
      sv39ptw_pkg::S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = sv39ptw_pkg::S_IDLE;
      end
      sv39ptw_pkg::S_IDLE: begin
        if (start_i) begin
          if (command_i == sv39ptw_pkg::CMD_WRITE) begin
            cmd_o.wr_en        = 1'b1;
            cmd_o.res_load     = 1'b1;
            cmd_o.res_zero_off = 1'b1;
          end else begin
            cmd_o.va_load = 1'b1;
            if (sts_i.va_big) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = sv39ptw_pkg::ST_TOO_LARGE;
            end else if (sts_i.root_out) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = sv39ptw_pkg::ST_OUTSIDE;
            end else begin
              // root entry read issued at the accepting edge
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = sv39ptw_pkg::SEL_ROOT;
              state_d      = sv39ptw_pkg::S_L2;
            end
          end
        end
      end
      sv39ptw_pkg::S_L2, sv39ptw_pkg::S_L1: begin
        if (!sts_i.pte_valid) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = sv39ptw_pkg::ST_MID_INVALID;
          state_d          = sv39ptw_pkg::S_IDLE;
        end else if (sts_i.pte_out) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = sv39ptw_pkg::ST_OUTSIDE;
          state_d          = sv39ptw_pkg::S_IDLE;
        end else begin
          cmd_o.rd_en = 1'b1;
          if (state_q == sv39ptw_pkg::S_L2) begin
            cmd_o.rd_sel = sv39ptw_pkg::SEL_MID;
            state_d      = sv39ptw_pkg::S_L1;
          end else begin
            cmd_o.rd_sel = sv39ptw_pkg::SEL_LEAF;
            state_d      = sv39ptw_pkg::S_L0;
          end
        end
      end
      sv39ptw_pkg::S_L0: begin
        cmd_o.res_load = 1'b1;
        state_d        = sv39ptw_pkg::S_IDLE;
        if (!sts_i.pte_valid) begin
          cmd_o.res_status = sv39ptw_pkg::ST_LEAF_INVALID;
        end else if (sts_i.user_fail) begin
          cmd_o.res_status = sv39ptw_pkg::ST_NOT_USER;
        end else begin
          cmd_o.res_pass_ppn = 1'b1;
        end
      end
      default: begin
        state_d = sv39ptw_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != sv39ptw_pkg::S_IDLE);

endmodule

`default_nettype wire

@@ rtl/sv39ptw_dpath.sv @@
// Walk datapath: table store, address muxing, PTE checks, result registers.
// Depends on sv39ptw_pkg; controlled by sv39ptw_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module sv39ptw_dpath #(
  parameter int TablePages = sv39ptw_pkg::TablePagesDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire sv39ptw_pkg::wk_cmd_t                cmd_i,
  output sv39ptw_pkg::wk_sts_t                     sts_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [sv39ptw_pkg::RootW-1:0]       cfg_root_i,
  input  wire logic [sv39ptw_pkg::EntryIdxW-1:0]   entry_index_i,
  input  wire logic [sv39ptw_pkg::PteW-1:0]        entry_value_i,
  input  wire logic [sv39ptw_pkg::VaW-1:0]         virtual_address_i,
  input  wire logic                                require_user_i,
  output logic                                     result_valid_o,
  output logic [2:0]                               status_o,
  output logic [sv39ptw_pkg::PpnW-1:0]             physical_page_o,
  output logic [sv39ptw_pkg::OffsetW-1:0]          page_offset_o
);

  localparam int StoreWords = TablePages * sv39ptw_pkg::EntriesPerPage;
  localparam int PageW      = (TablePages > 1) ? $clog2(TablePages) : 1;
  localparam int AddrW      = PageW + sv39ptw_pkg::LevelIdxW;
  localparam int LvlW       = sv39ptw_pkg::LevelIdxW;
  localparam int OffW       = sv39ptw_pkg::OffsetW;
  localparam int PpnW       = sv39ptw_pkg::PpnW;

  // Table store: one write port, one registered read port
  logic [sv39ptw_pkg::PteW-1:0] mem [0:StoreWords-1];
  logic [sv39ptw_pkg::PteW-1:0] rdata_q;

  logic [AddrW-1:0]              clr_q, clr_d;
  logic [sv39ptw_pkg::RootW-1:0] root_q;
  logic [2*LvlW+OffW-1:0]        va_q;
  logic                          ru_q;

  logic                          res_valid_q;
  sv39ptw_pkg::status_e          status_q;
  logic [PpnW-1:0]               ppn_q;
  logic [OffW-1:0]               off_q;

  logic [AddrW-1:0]              waddr, raddr;
  logic [sv39ptw_pkg::PteW-1:0]  wdata;
  logic                          we;
  logic [15:0]                   idx_ext;
  logic                          idx_in_range;
  logic [7:0]                    root_ext;
  logic [PpnW-1:0]               pte_ppn;
  logic [PageW-1:0]              page_sel;
  logic [LvlW-1:0]               lvl_idx;

  // Write address/data: clearing pass or write command
  assign idx_ext      = {4'b0, entry_index_i};
  assign idx_in_range = (idx_ext < 16'(StoreWords));
  assign we           = cmd_i.clr_en | (cmd_i.wr_en & idx_in_range);
  assign waddr        = cmd_i.clr_en ? clr_q : idx_ext[AddrW-1:0];
  assign wdata        = cmd_i.clr_en ? '0 : entry_value_i;

  // Read address: root page from config, later pages from the last PTE
  assign root_ext = {5'b0, root_q};
  assign pte_ppn  = rdata_q[sv39ptw_pkg::PtePpnLsb +: PpnW];

  always_comb begin
    case (cmd_i.rd_sel)
      sv39ptw_pkg::SEL_ROOT: begin
        page_sel = root_ext[PageW-1:0];
        lvl_idx  = virtual_address_i[OffW+2*LvlW +: LvlW];
      end
      sv39ptw_pkg::SEL_MID: begin
        page_sel = pte_ppn[PageW-1:0];
        lvl_idx  = va_q[OffW+LvlW +: LvlW];
      end
      sv39ptw_pkg::SEL_LEAF: begin
        page_sel = pte_ppn[PageW-1:0];
        lvl_idx  = va_q[OffW +: LvlW];
      end
      default: begin
        page_sel = '0;
        lvl_idx  = '0;
      end
    endcase
  end

  assign raddr = {page_sel, lvl_idx};

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem[raddr];
  end

  // Clear sweep counter
  assign clr_d = clr_q + AddrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      root_q <= '0;
    end else begin
      if (cmd_i.clr_en) clr_q <= clr_d;
      if (cfg_we_i) root_q <= cfg_root_i;
    end
  end

  // Latched walk operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.va_load) begin
      va_q <= virtual_address_i[2*LvlW+OffW-1:0];
      ru_q <= require_user_i;
    end
  end

  // Status back to the controller
  assign sts_o.clr_last  = (clr_q == AddrW'(StoreWords - 1));
  assign sts_o.va_big    = virtual_address_i[sv39ptw_pkg::VaW-1];
  assign sts_o.root_out  = (root_ext >= 8'(TablePages));
  assign sts_o.pte_valid = rdata_q[sv39ptw_pkg::PteValidBit];
  assign sts_o.pte_out   = (pte_ppn >= PpnW'(TablePages));
  assign sts_o.user_fail = ru_q & ~rdata_q[sv39ptw_pkg::PteUserBit];

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.res_load;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q <= cmd_i.res_status;
      ppn_q    <= cmd_i.res_pass_ppn ? pte_ppn : '0;
      if (cmd_i.res_zero_off) begin
        off_q <= '0;
      end else if (cmd_i.va_load) begin
        off_q <= virtual_address_i[OffW-1:0];
      end else begin
        off_q <= va_q[OffW-1:0];
      end
    end
  end

  assign result_valid_o  = res_valid_q;
  assign status_o        = status_q;
  assign physical_page_o = ppn_q;
  assign page_offset_o   = off_q;

endmodule

`default_nettype wire

@@ rtl/sv39_page_table_walker.sv @@
// Sv39 page-table walker top level: controller plus datapath.
// Depends on sv39ptw_pkg, sv39ptw_ctrl and sv39ptw_dpath.
//
// Usage:
//   Commands enter on start/busy: a transaction is taken at a rising edge
//   with start high and busy low. command_i = 0 writes entry_value_i to
//   store word entry_index_i (ignored beyond the store); command_i = 1
//   translates virtual_address_i, optionally requiring the leaf U bit.
//   Every command yields one result, shown for one cycle with
//   result_valid_o high; the receiver must take it then.
//   Writes and early faults (address too large, root outside the store)
//   give the result in the cycle after acceptance. A full walk does three
//   dependent reads of the synchronous table memory, one per cycle, issued
//   at acceptance and in states L2 and L1, checks the leaf in L0, then
//   registers the result; busy drops in time for the next command to be
//   accepted during the result cycle. Faults at level 2 or 1 end early.
//   Reset: the store is cleared by a sweep of TablePages * 512 words
//   (4096 by default), one word per cycle, with busy high. The root page
//   register resets to 0 and may be written at any time, also during the
//   sweep, through root_table_page_we_i.
`timescale 1ns / 1ps
`default_nettype none

module sv39_page_table_walker #(
  parameter int TablePages = sv39ptw_pkg::TablePagesDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               root_table_page_we_i,
  input  wire logic [sv39ptw_pkg::RootW-1:0]      root_table_page_i,
  input  wire logic                               command_i,
  input  wire logic [sv39ptw_pkg::EntryIdxW-1:0]  entry_index_i,
  input  wire logic [sv39ptw_pkg::PteW-1:0]       entry_value_i,
  input  wire logic [sv39ptw_pkg::VaW-1:0]        virtual_address_i,
  input  wire logic                               require_user_i,
  output logic                                    result_valid_o,
  output logic [2:0]                              status_o,
  output logic [sv39ptw_pkg::PpnW-1:0]            physical_page_o,
  output logic [sv39ptw_pkg::OffsetW-1:0]         page_offset_o
);

  sv39ptw_pkg::wk_cmd_t cmd;
  sv39ptw_pkg::wk_sts_t sts;

  // Sequencer
  sv39ptw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  // Store and result path
  sv39ptw_dpath #(
    .TablePages (TablePages)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (root_table_page_we_i),
    .cfg_root_i        (root_table_page_i),
    .entry_index_i     (entry_index_i),
    .entry_value_i     (entry_value_i),
    .virtual_address_i (virtual_address_i),
    .require_user_i    (require_user_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .physical_page_o   (physical_page_o),
    .page_offset_o     (page_offset_o)
  );

endmodule

`default_nettype wire

@@ rtl/sv39ptw_checker.sv @@
// Port-level checker for the Sv39 page-table walker, bound to the top level.
// Depends on sv39ptw_pkg and sv39_page_table_walker_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sv39_page_table_walker_assert.svh"

module sv39ptw_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               command_i,
  input wire logic [sv39ptw_pkg::VaW-1:0]        virtual_address_i,
  input wire logic                               result_valid_o,
  input wire logic [2:0]                         status_o,
  input wire logic [sv39ptw_pkg::PpnW-1:0]       physical_page_o,
  input wire logic [sv39ptw_pkg::OffsetW-1:0]    page_offset_o
);

  logic acc_wr, acc_tr;

  assign acc_wr = start && !busy && (command_i == sv39ptw_pkg::CMD_WRITE);
  assign acc_tr = start && !busy && (command_i == sv39ptw_pkg::CMD_TRANSLATE);

  // Results only appear once the block is free for the next command
  `SV39PTW_ASSERT_NOW(a_res_idle, clk_i, rst_ni, result_valid_o, !busy)

  // A write transaction answers next cycle with an all-zero result
  `SV39PTW_ASSERT_NEXT(a_wr_res, clk_i, rst_ni, acc_wr,
    result_valid_o && (status_o == sv39ptw_pkg::ST_OK) &&
    (physical_page_o == '0) && (page_offset_o == '0))

  // An address at or above 2^38 faults right away
  `SV39PTW_ASSERT_NEXT(a_va_big, clk_i, rst_ni,
    acc_tr && virtual_address_i[sv39ptw_pkg::VaW-1],
    result_valid_o && (status_o == sv39ptw_pkg::ST_TOO_LARGE))

  // A translate either walks or answers at once
  `SV39PTW_ASSERT_NEXT(a_tr_progress, clk_i, rst_ni, acc_tr, busy || result_valid_o)

  // Fault results carry no physical page
  `SV39PTW_ASSERT_NOW(a_fault_ppn, clk_i, rst_ni,
    result_valid_o && (status_o != sv39ptw_pkg::ST_OK), physical_page_o == '0)

endmodule

bind sv39_page_table_walker sv39ptw_checker u_sv39ptw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .command_i         (command_i),
  .virtual_address_i (virtual_address_i),
  .result_valid_o    (result_valid_o),
  .status_o          (status_o),
  .physical_page_o   (physical_page_o),
  .page_offset_o     (page_offset_o)
);

`default_nettype wire
